### hdl/cavlc_ld_pkg.sv
// Shared types and constants for the CAVLC level decoder.
// No dependencies; used by every module of the block.
package cavlc_ld_pkg;

   localparam int MAX_LEVEL_PREFIX = 25;
   localparam int LEVEL_W          = 24;
   localparam int SUFFIX_W         = MAX_LEVEL_PREFIX - 3;
   localparam int CODE_W           = (SUFFIX_W + 3 > LEVEL_W + 1) ? SUFFIX_W + 3 : LEVEL_W + 1;

   localparam int COEF_COUNT_MAX   = 16;
   localparam int ESC_PREFIX       = 15;
   localparam int ESC4_PREFIX      = 14;
   localparam int ESC4_SIZE        = 4;
   localparam int ESC_EXT_PREFIX   = 16;
   localparam int ESC_EXT_OFFSET   = 4096;
   localparam int ESC_BIAS         = 15;
   localparam int T1_BIAS          = 2;
   localparam int T1_MAX           = 3;
   localparam int SL_BOOST_TOTAL   = 10;
   localparam int SL_MAX           = 6;
   localparam int PREFIX_SIZE_OFS  = 3;

   typedef logic [CODE_W-1:0]          code_type;
   typedef logic signed [LEVEL_W-1:0]  level_type;
   typedef logic [SUFFIX_W-1:0]        suffix_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SIGN   = 2'd1,
      PH_PREFIX = 2'd2,
      PH_SUFFIX = 2'd3
   } phase_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BIT   = 1'b1
   } cmd_type;

   typedef struct packed {
      logic       command;
      logic       bit_val;
      logic [4:0] coef_count;
      logic [1:0] t1_count;
   } req_word_type;

   typedef struct packed {
      level_type  level;
      logic [3:0] coeff_index;
      logic       last;
      logic       error;
   } rsp_word_type;

endpackage

### hdl/cavlc_ld_core.sv
// Level decode state machine: trailing-one signs, unary prefix, suffix bits.
// Depends on cavlc_ld_pkg; each accepted word updates the state registers once.
module cavlc_ld_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  cavlc_ld_pkg::req_word_type  req,
   output logic                        res_valid,
   output cavlc_ld_pkg::rsp_word_type  res
);

   cavlc_ld_pkg::phase_type  phase_ff, phase_in;
   logic [4:0]               done_ff, done_in;
   logic [4:0]               total_ff, total_in;
   logic [1:0]               ones_ff, ones_in;
   logic [2:0]               sl_ff, sl_in;
   logic [4:0]               prefix_ff, prefix_in;
   logic [4:0]               left_ff, left_in;
   cavlc_ld_pkg::suffix_type sv_ff, sv_in;

   cavlc_ld_pkg::suffix_type sv_shift, fin_sv;
   logic [4:0]               left_dec, size, tc_sat, done_inc;
   logic [1:0]               t1_clamp;
   logic [3:0]               eff;
   cavlc_ld_pkg::code_type   code, mag, thresh;
   logic                     neg;
   logic [2:0]               sl0, sl_new;
   cavlc_ld_pkg::level_type  fin_level;
   logic                     do_fin, do_adv, is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cavlc_ld_pkg::PH_IDLE;
         done_ff   <= '0;
         total_ff  <= '0;
         ones_ff   <= '0;
         sl_ff     <= '0;
         prefix_ff <= '0;
         left_ff   <= '0;
         sv_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         done_ff   <= done_in;
         total_ff  <= total_in;
         ones_ff   <= ones_in;
         sl_ff     <= sl_in;
         prefix_ff <= prefix_in;
         left_ff   <= left_in;
         sv_ff     <= sv_in;
      end
   end

   // level reconstruction
   always_comb begin
      sv_shift = {sv_ff[cavlc_ld_pkg::SUFFIX_W-2:0], req.bit_val};
      fin_sv   = (phase_ff == cavlc_ld_pkg::PH_SUFFIX) ? sv_shift : '0;
      eff      = (prefix_ff > 5'(cavlc_ld_pkg::ESC_PREFIX)) ?
                 4'(cavlc_ld_pkg::ESC_PREFIX) : prefix_ff[3:0];
      code     = (cavlc_ld_pkg::code_type'(eff) << sl_ff) + cavlc_ld_pkg::code_type'(fin_sv);
      if (prefix_ff >= 5'(cavlc_ld_pkg::ESC_PREFIX) && sl_ff == 3'd0)
         code = code + cavlc_ld_pkg::code_type'(cavlc_ld_pkg::ESC_BIAS);
      if (prefix_ff >= 5'(cavlc_ld_pkg::ESC_EXT_PREFIX))
         code = code - cavlc_ld_pkg::code_type'(cavlc_ld_pkg::ESC_EXT_OFFSET) +
                (cavlc_ld_pkg::code_type'(1) << (prefix_ff - 5'(cavlc_ld_pkg::PREFIX_SIZE_OFS)));
      if (done_ff == {3'd0, ones_ff} && ones_ff < 2'(cavlc_ld_pkg::T1_MAX))
         code = code + cavlc_ld_pkg::code_type'(cavlc_ld_pkg::T1_BIAS);
      neg = code[0];
      mag = {1'b0, code[cavlc_ld_pkg::CODE_W-1:1]} + cavlc_ld_pkg::code_type'(1);
      if (!neg && mag > cavlc_ld_pkg::code_type'((1 << (cavlc_ld_pkg::LEVEL_W - 1)) - 1))
         fin_level = cavlc_ld_pkg::level_type'((1 << (cavlc_ld_pkg::LEVEL_W - 1)) - 1);
      else if (neg && mag > cavlc_ld_pkg::code_type'(1 << (cavlc_ld_pkg::LEVEL_W - 1)))
         fin_level = cavlc_ld_pkg::level_type'(1 << (cavlc_ld_pkg::LEVEL_W - 1));
      else
         fin_level = neg ? cavlc_ld_pkg::level_type'(-mag) : cavlc_ld_pkg::level_type'(mag);
      sl0    = (sl_ff == 3'd0) ? 3'd1 : sl_ff;
      thresh = cavlc_ld_pkg::code_type'(3) << (sl0 - 3'd1);
      sl_new = (mag > thresh && sl0 < 3'(cavlc_ld_pkg::SL_MAX)) ? sl0 + 3'd1 : sl0;
   end

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      done_in   = done_ff;
      total_in  = total_ff;
      ones_in   = ones_ff;
      sl_in     = sl_ff;
      prefix_in = prefix_ff;
      left_in   = left_ff;
      sv_in     = sv_ff;
      res_valid = 1'b0;
      res       = '0;
      do_fin    = 1'b0;
      do_adv    = 1'b0;
      done_inc  = done_ff + 5'd1;
      is_last   = (done_inc == total_ff);
      left_dec  = (left_ff != 5'd0) ? left_ff - 5'd1 : 5'd0;
      tc_sat    = (req.coef_count > 5'(cavlc_ld_pkg::COEF_COUNT_MAX)) ?
                  5'(cavlc_ld_pkg::COEF_COUNT_MAX) : req.coef_count;
      t1_clamp  = ({3'd0, req.t1_count} > tc_sat) ? tc_sat[1:0] : req.t1_count;
      size      = {2'd0, sl_ff};
      if (prefix_ff == 5'(cavlc_ld_pkg::ESC4_PREFIX) && sl_ff == 3'd0)
         size = 5'(cavlc_ld_pkg::ESC4_SIZE);
      if (prefix_ff >= 5'(cavlc_ld_pkg::ESC_PREFIX))
         size = prefix_ff - 5'(cavlc_ld_pkg::PREFIX_SIZE_OFS);

      if (accept) begin
         if (req.command == cavlc_ld_pkg::CMD_START) begin
            total_in  = tc_sat;
            ones_in   = t1_clamp;
            done_in   = '0;
            prefix_in = '0;
            left_in   = '0;
            sv_in     = '0;
            sl_in     = (tc_sat > 5'(cavlc_ld_pkg::SL_BOOST_TOTAL) &&
                         t1_clamp < 2'(cavlc_ld_pkg::T1_MAX)) ? 3'd1 : 3'd0;
            if (tc_sat == 5'd0)
               phase_in = cavlc_ld_pkg::PH_IDLE;
            else if (t1_clamp != 2'd0)
               phase_in = cavlc_ld_pkg::PH_SIGN;
            else
               phase_in = cavlc_ld_pkg::PH_PREFIX;
         end else begin
            case (phase_ff)
               cavlc_ld_pkg::PH_SIGN: begin
                  res_valid = 1'b1;
                  res.level = req.bit_val ? cavlc_ld_pkg::level_type'(-1) :
                                            cavlc_ld_pkg::level_type'(1);
                  do_adv    = 1'b1;
               end
               cavlc_ld_pkg::PH_PREFIX: begin
                  if (!req.bit_val) begin
                     if (prefix_ff >= 5'(cavlc_ld_pkg::MAX_LEVEL_PREFIX)) begin
                        res_valid = 1'b1;
                        res.error = 1'b1;
                        phase_in  = cavlc_ld_pkg::PH_IDLE;
                     end else begin
                        prefix_in = prefix_ff + 5'd1;
                     end
                  end else begin
                     sv_in = '0;
                     if (size != 5'd0) begin
                        left_in  = size;
                        phase_in = cavlc_ld_pkg::PH_SUFFIX;
                     end else begin
                        do_fin = 1'b1;
                        do_adv = 1'b1;
                     end
                  end
               end
               cavlc_ld_pkg::PH_SUFFIX: begin
                  sv_in   = sv_shift;
                  left_in = left_dec;
                  if (left_dec == 5'd0) begin
                     do_fin = 1'b1;
                     do_adv = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end

      if (do_fin) begin
         res_valid = 1'b1;
         res.level = fin_level;
         sl_in     = sl_new;
      end
      res.coeff_index = done_ff[3:0];
      res.last        = res.error | is_last;
      if (do_adv) begin
         done_in = done_inc;
         if (done_inc >= total_ff) begin
            phase_in = cavlc_ld_pkg::PH_IDLE;
         end else if (done_inc < {3'd0, ones_ff}) begin
            phase_in = cavlc_ld_pkg::PH_SIGN;
         end else begin
            phase_in  = cavlc_ld_pkg::PH_PREFIX;
            prefix_in = '0;
         end
      end
   end

endmodule

### hdl/cavlc_ld_outbuf.sv
// Two-entry result buffer: output register plus skid word.
// Depends on cavlc_ld_pkg for the result word type.
module cavlc_ld_outbuf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  cavlc_ld_pkg::rsp_word_type  in_word,
   output logic                        full,
   output logic                        out_valid,
   input  logic                        out_stall,
   output cavlc_ld_pkg::rsp_word_type  out_word
);

   logic                       main_v_ff, skid_v_ff;
   cavlc_ld_pkg::rsp_word_type main_ff, skid_ff;
   logic                       pop;

   assign pop       = main_v_ff & ~out_stall;
   assign full      = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_word  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            main_ff   <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (in_valid) begin
         if (!main_v_ff || pop) begin
            main_ff   <= in_word;
            main_v_ff <= 1'b1;
         end else begin
            skid_ff   <= in_word;
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         main_v_ff <= 1'b0;
      end
   end

endmodule

### hdl/cavlc_level_decoder.sv
// CAVLC level decoder top level: one bitstream word per cycle while req_stall is low, no bubbles.
// A level that a word completes is registered in the output buffer before it appears on rsp_.
// Throughput: one req_ word per cycle while req_stall is low; the decode state updates once per word.
// Two result words are buffered; req_stall rises only when both are held.
// Reset (synchronous): block goes idle, all counters clear, buffer empties.
module cavlc_level_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic                               req_bit_req,
   input  logic [4:0]                         req_coef_count,
   input  logic [1:0]                         req_t1_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cavlc_ld_pkg::LEVEL_W-1:0] rsp_level,
   output logic [3:0]                         rsp_coeff_index,
   output logic                               rsp_last,
   output logic                               rsp_error
);

   cavlc_ld_pkg::req_word_type req;
   cavlc_ld_pkg::rsp_word_type res, out_word;
   logic                       accept, res_valid, full;

   assign accept    = req_valid & ~full;
   assign req_stall = full;
   assign req       = {req_command, req_bit_req, req_coef_count, req_t1_count};

   cavlc_ld_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .res_valid (res_valid),
      .res       (res)
   );

   cavlc_ld_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_word   (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_level       = out_word.level;
   assign rsp_coeff_index = out_word.coeff_index;
   assign rsp_last        = out_word.last;
   assign rsp_error       = out_word.error;

endmodule

### hdl/cavlc_ld_checker.sv
// Port-level checks for cavlc_level_decoder, bound to the top level.
// Depends on cavlc_ld_pkg for the level width.
module cavlc_ld_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [cavlc_ld_pkg::LEVEL_W-1:0] rsp_level,
   input logic [3:0]                              rsp_coeff_index,
   input logic                                    rsp_last,
   input logic                                    rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_level) && $stable(rsp_coeff_index))
      else $error("stalled rsp word changed");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last)
      else $error("error word without last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_level == '0)
      else $error("error word with nonzero level");

   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_level != '0)
      else $error("decoded level is zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("buffer not empty after reset");

endmodule

bind cavlc_level_decoder cavlc_ld_checker u_checker (.*);

### tb/cavlc_level_decoder_tb.sv
// Self-checking testbench for cavlc_level_decoder: drives start and bit words,
// predicts every level word in a scoreboard class and checks it field by field.
// Depends on hdl/cavlc_ld_pkg.sv and hdl/cavlc_level_decoder.sv.
module cavlc_level_decoder_tb;

   localparam int RANDOM_WORDS   = 1700;
   localparam int WATCHDOG_LIMIT = 2000;

   class level_scoreboard;
      cavlc_ld_pkg::phase_type    ph = cavlc_ld_pkg::PH_IDLE;
      int unsigned                done, total, ones, sfx_len, pfx, sfx_left, sfx_val;
      int unsigned                errors;
      cavlc_ld_pkg::rsp_word_type expected_levels[$];

      task report(string what);
         $display("%0t: %s", $time, what);
         errors++;
      endtask

      function cavlc_ld_pkg::rsp_word_type pack_level(longint lv, bit err, bit lst);
         cavlc_ld_pkg::rsp_word_type w;
         longint hi = (longint'(1) << (cavlc_ld_pkg::LEVEL_W - 1)) - 1;
         if (lv > hi) lv = hi;
         if (lv < -hi - 1) lv = -hi - 1;
         w.level       = cavlc_ld_pkg::level_type'(lv);
         w.coeff_index = done[3:0];
         w.last        = lst;
         w.error       = err;
         return w;
      endfunction

      function void advance();
         done++;
         if (done >= total) begin
            ph = cavlc_ld_pkg::PH_IDLE;
         end else if (done < ones) begin
            ph = cavlc_ld_pkg::PH_SIGN;
         end else begin
            ph  = cavlc_ld_pkg::PH_PREFIX;
            pfx = 0;
         end
      endfunction

      function longint finish_level();
         int unsigned pre = pfx;
         int unsigned sl  = sfx_len;
         int unsigned eff = (pfx > cavlc_ld_pkg::ESC_PREFIX) ? cavlc_ld_pkg::ESC_PREFIX : pfx;
         longint code = (longint'(eff) << sl) + longint'(sfx_val);
         longint lv, mag;
         if (pre >= cavlc_ld_pkg::ESC_PREFIX && sl == 0) code += cavlc_ld_pkg::ESC_BIAS;
         if (pre >= cavlc_ld_pkg::ESC_EXT_PREFIX)
            code += (longint'(1) << (pre - cavlc_ld_pkg::PREFIX_SIZE_OFS)) -
                    cavlc_ld_pkg::ESC_EXT_OFFSET;
         if (done == ones && ones < cavlc_ld_pkg::T1_MAX) code += cavlc_ld_pkg::T1_BIAS;
         if (code[0] == 1'b0) lv = (code + 2) / 2;
         else lv = -((code + 1) / 2);
         if (sl == 0) sl = 1;
         mag = (lv < 0) ? -lv : lv;
         if (mag > (longint'(3) << (sl - 1)) && sl < cavlc_ld_pkg::SL_MAX) sl++;
         sfx_len = sl;
         return lv;
      endfunction

      // returns 1 when the word completes a level (or aborts the block)
      function bit predict(input cavlc_ld_pkg::cmd_type cmd, input logic b,
                           input logic [4:0] tc_in, input logic [1:0] t1_in,
                           output cavlc_ld_pkg::rsp_word_type w);
         int unsigned tc, t1, size;
         bit lst;
         w = '0;
         if (cmd == cavlc_ld_pkg::CMD_START) begin
            tc = (tc_in > cavlc_ld_pkg::COEF_COUNT_MAX) ? cavlc_ld_pkg::COEF_COUNT_MAX : tc_in;
            t1 = (t1_in > tc) ? tc : t1_in;
            total    = tc;
            ones     = t1;
            done     = 0;
            pfx      = 0;
            sfx_left = 0;
            sfx_val  = 0;
            sfx_len  = (tc > cavlc_ld_pkg::SL_BOOST_TOTAL && t1 < cavlc_ld_pkg::T1_MAX) ? 1 : 0;
            if (tc == 0) ph = cavlc_ld_pkg::PH_IDLE;
            else if (t1 > 0) ph = cavlc_ld_pkg::PH_SIGN;
            else ph = cavlc_ld_pkg::PH_PREFIX;
            return 0;
         end
         case (ph)
            cavlc_ld_pkg::PH_SIGN: begin
               lst = (done + 1 == total);
               w = pack_level(b ? -1 : 1, 1'b0, lst);
               advance();
               return 1;
            end
            cavlc_ld_pkg::PH_PREFIX: begin
               if (!b) begin
                  if (pfx >= cavlc_ld_pkg::MAX_LEVEL_PREFIX) begin
                     w  = pack_level(0, 1'b1, 1'b1);
                     ph = cavlc_ld_pkg::PH_IDLE;
                     return 1;
                  end
                  pfx++;
                  return 0;
               end
               size = sfx_len;
               if (pfx == cavlc_ld_pkg::ESC4_PREFIX && sfx_len == 0)
                  size = cavlc_ld_pkg::ESC4_SIZE;
               if (pfx >= cavlc_ld_pkg::ESC_PREFIX) size = pfx - cavlc_ld_pkg::PREFIX_SIZE_OFS;
               sfx_val = 0;
               if (size > 0) begin
                  sfx_left = size;
                  ph = cavlc_ld_pkg::PH_SUFFIX;
                  return 0;
               end
               lst = (done + 1 == total);
               w = pack_level(finish_level(), 1'b0, lst);
               advance();
               return 1;
            end
            cavlc_ld_pkg::PH_SUFFIX: begin
               sfx_val = (sfx_val << 1) | b;
               if (sfx_left > 0) sfx_left--;
               if (sfx_left != 0) return 0;
               lst = (done + 1 == total);
               w = pack_level(finish_level(), 1'b0, lst);
               advance();
               return 1;
            end
            default: return 0;
         endcase
      endfunction

      function void note(cavlc_ld_pkg::cmd_type cmd, logic b, logic [4:0] tc, logic [1:0] t1);
         cavlc_ld_pkg::rsp_word_type w;
         if (predict(cmd, b, tc, t1, w)) expected_levels.push_back(w);
      endfunction

      task check(cavlc_ld_pkg::rsp_word_type got);
         cavlc_ld_pkg::rsp_word_type want;
         if (expected_levels.size() == 0) begin
            report($sformatf("unexpected word: level %0d index %0d",
                             got.level, got.coeff_index));
            return;
         end
         want = expected_levels.pop_front();
         if (got.level !== want.level)
            report($sformatf("level %0d, want %0d", got.level, want.level));
         if (got.coeff_index !== want.coeff_index)
            report($sformatf("coeff_index %0d, want %0d", got.coeff_index, want.coeff_index));
         if (got.last !== want.last)
            report($sformatf("last %0b, want %0b", got.last, want.last));
         if (got.error !== want.error)
            report($sformatf("error %0b, want %0b", got.error, want.error));
      endtask

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_stall;
   logic                    req_command     = 1'b0;
   logic                    req_bit_req     = 1'b0;
   logic [4:0]              req_coef_count  = '0;
   logic [1:0]              req_t1_count    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall       = 1'b0;
   cavlc_ld_pkg::level_type rsp_level;
   logic [3:0]              rsp_coeff_index;
   logic                    rsp_last;
   logic                    rsp_error;

   int unsigned             idle_pct    = 0;
   int unsigned             stall_pct   = 0;
   int unsigned             idle_cycles = 0;
   int unsigned             sent_words  = 0;

   level_scoreboard levels_sb = new;
   level_scoreboard gen_model = new;

   cavlc_level_decoder DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_bit_req     (req_bit_req),
      .req_coef_count  (req_coef_count),
      .req_t1_count    (req_t1_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_level       (rsp_level),
      .rsp_coeff_index (rsp_coeff_index),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : monitor
      cavlc_ld_pkg::rsp_word_type got;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            levels_sb.note(cavlc_ld_pkg::cmd_type'(req_command), req_bit_req, req_coef_count,
                           req_t1_count);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.level       = rsp_level;
            got.coeff_index = rsp_coeff_index;
            got.last        = rsp_last;
            got.error       = rsp_error;
            levels_sb.check(got);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cavlc_level_decoder: mismatch");
            $finish;
         end
      end
   end

   task send_word(input cavlc_ld_pkg::cmd_type cmd, input logic b, input logic [4:0] tc,
                  input logic [1:0] t1);
      cavlc_ld_pkg::rsp_word_type scratch_word;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_bit_req    <= b;
      req_coef_count <= tc;
      req_t1_count   <= t1;
      do @(posedge clock); while (req_stall);
      void'(gen_model.predict(cmd, b, tc, t1, scratch_word));
      sent_words++;
   endtask

   task send_start(input logic [4:0] tc, input logic [1:0] t1);
      send_word(cavlc_ld_pkg::CMD_START, 1'($urandom_range(1)), tc, t1);
   endtask

   task send_bit(input logic b);
      send_word(cavlc_ld_pkg::CMD_BIT, b, 5'($urandom_range(31)), 2'($urandom_range(3)));
   endtask

   // one block: mostly well-formed levels with chosen prefix lengths,
   // sometimes cut short by the next start or trailed by stray bits
   task random_block();
      int unsigned r, tc, target, cut, n;
      r  = $urandom_range(99);
      tc = (r < 6) ? $urandom_range(31, 17) : (r < 10) ? 0 : $urandom_range(16, 1);
      send_start(5'(tc), 2'($urandom_range(3)));
      cut    = ($urandom_range(9) == 0) ? $urandom_range(12) : 32'hffff;
      n      = 0;
      target = 0;
      while (gen_model.ph != cavlc_ld_pkg::PH_IDLE && n < cut) begin
         if (gen_model.ph == cavlc_ld_pkg::PH_PREFIX) begin
            if (gen_model.pfx == 0) begin
               r = $urandom_range(99);
               if (r < 55) target = $urandom_range(3);
               else if (r < 75) target = $urandom_range(13, 4);
               else if (r < 80) target = cavlc_ld_pkg::ESC4_PREFIX;
               else if (r < 85) target = cavlc_ld_pkg::ESC_PREFIX;
               else if (r < 97)
                  target = $urandom_range(cavlc_ld_pkg::MAX_LEVEL_PREFIX,
                                          cavlc_ld_pkg::ESC_EXT_PREFIX);
               else target = cavlc_ld_pkg::MAX_LEVEL_PREFIX + 1;
            end
            send_bit(gen_model.pfx >= target);
         end else begin
            send_bit(1'($urandom_range(1)));
         end
         n++;
      end
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(3, 1)) send_bit(1'($urandom_range(1)));
   endtask

   initial begin : stimulus
      int unsigned base, quarter;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_bit(1'b1);                 // idle: ignored
      send_start(5'd0, 2'd2);         // empty block
      send_bit(1'b0);
      send_start(5'd31, 2'd3);        // count saturates to 16
      send_bit(1'b1);
      send_bit(1'b0);
      send_bit(1'b1);
      send_bit(1'b1);
      send_start(5'd1, 2'd3);         // trailing ones clamped to total
      send_bit(1'b1);
      send_start(5'd2, 2'd0);
      send_bit(1'b0);
      send_bit(1'b0);
      send_start(5'd11, 2'd1);        // restart mid-level, suffix length 1
      send_bit(1'b0);
      send_bit(1'b1);
      send_bit(1'b1);

      base = sent_words;
      while (sent_words < base + RANDOM_WORDS) begin
         quarter = (sent_words - base) * 4 / RANDOM_WORDS;
         case (quarter)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 64;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 64;
            end
            default: begin
               idle_pct  = 6;
               stall_pct = 6;
            end
         endcase
         random_block();
      end

      req_valid <= 1'b0;
      while (levels_sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (levels_sb.errors == 0)
         $display("cavlc_level_decoder: match");
      else
         $display("cavlc_level_decoder: mismatch");
      $finish;
   end

endmodule
